// ===== rtl/olpt_pkg.sv =====
package olpt_pkg;

  localparam int SLOTS = 1024;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int STAT_W = 3;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_FULL  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  localparam logic [1:0] FN_INSERT  = 2'd0;
  localparam logic [1:0] FN_QUERY   = 2'd1;
  localparam logic [1:0] FN_REMOVE  = 2'd2;
  localparam logic [1:0] FN_REBUILD = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_DUE       = 3'd4;

  typedef struct packed {
    logic [1:0]       mark;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } ovf_t;

  typedef enum logic [5:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_RES_FULL,
    OP_PINIT,
    OP_RD_S,
    OP_PSTEP,
    OP_RES_DUP,
    OP_RES_NF,
    OP_RES_QHIT,
    OP_TOMB,
    OP_EMPTY_HEAD,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_END,
    OP_COPY_RD,
    OP_COPY_WR,
    OP_PLACE,
    OP_PLACE_RB,
    OP_RB1_RD,
    OP_RB1_EX,
    OP_RB1_END,
    OP_RB2_PRD,
    OP_RB2_PSKIP,
    OP_RB2_QRD,
    OP_RB2_QCLR,
    OP_RB2_MOVE,
    OP_RB2_CLR,
    OP_RB3_INIT,
    OP_RB3_RD,
    OP_RB3_LD,
    OP_RB4_INIT,
    OP_RB4_RD,
    OP_RB4_EX,
    OP_RB5,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic tbl_full;
    logic hit;
    logic stop;
    logic step_to_head;
    logic rd_empty;
    logic rd_full;
    logic scan_more;
    logic copy_done;
    logic rb1_done;
    logic p_end;
    logic q_end;
    logic move_same;
    logic ovf_done;
    logic clr_done;
  } dp_flags_t;

  // Home slot: top bits of key * SLOTS, which for a power-of-two table is a bit slice.
  function automatic logic [IDX_W-1:0] home_of(input logic [KEY_W-1:0] k);
    return k[KEY_W-1 -: IDX_W];
  endfunction

  function automatic logic [IDX_W-1:0] nxt_slot(input logic [IDX_W-1:0] s);
    return (s == IDX_W'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] prv_slot(input logic [IDX_W-1:0] s);
    return (s == '0) ? IDX_W'(SLOTS - 1) : s - 1'b1;
  endfunction

endpackage

// ===== rtl/olpt_dpath.sv =====
module olpt_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  olpt_pkg::dp_op_t              op,
  input  logic [olpt_pkg::KEY_W-1:0]    key,
  input  logic [olpt_pkg::VAL_W-1:0]    value_in,
  output olpt_pkg::dp_flags_t           flags,
  output logic [olpt_pkg::STAT_W-1:0]   status,
  output logic [olpt_pkg::VAL_W-1:0]    value_out,
  output logic [olpt_pkg::CNT_W-1:0]    probe_misses
);
  import olpt_pkg::*;

  slot_t tbl_mem [SLOTS];
  slot_t rdata;
  ovf_t  ovf_mem [SLOTS];
  ovf_t  ovf_rdata;

  logic [KEY_W-1:0]  ckey;
  logic [VAL_W-1:0]  cval;
  logic [IDX_W-1:0]  s, e, head;
  logic [CNT_W-1:0]  m, n_sh, p, q, rec, tomb, cd, ovf_n, ovf_i;
  logic              wrapped;
  logic [STAT_W-1:0] res_status;
  logic [VAL_W-1:0]  res_value;
  logic [CNT_W-1:0]  res_miss;

  logic              rd_en, wr_en, ovf_wr_en, ovf_rd_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  slot_t             wr_data;

  logic [IDX_W-1:0]  home_c, home_r, s_nxt, e_nxt, p_prv;
  logic [CNT_W-1:0]  pn, rec_dec, cd_dec, cd_reload;
  logic              rd_full;

  assign home_c  = home_of(ckey);
  assign home_r  = home_of(rdata.key);
  assign s_nxt   = nxt_slot(s);
  assign e_nxt   = nxt_slot(e);
  assign p_prv   = prv_slot(p[IDX_W-1:0]);
  assign pn      = (p > {1'b0, home_r}) ? p : {1'b0, home_r};
  assign rec_dec = (rec != '0) ? rec - 1'b1 : rec;
  assign cd_dec  = (cd != '0) ? cd - 1'b1 : cd;
  // (SLOTS/2 * (SLOTS - records)) / SLOTS reduces to a halving for a power-of-two table.
  assign cd_reload = (CNT_W'(SLOTS) - rec) >> 1;
  assign rd_full = (rdata.mark == MARK_FULL);

  always_comb begin
    flags.tbl_full     = (rec >= CNT_W'(SLOTS));
    flags.hit          = rd_full && (rdata.key == ckey);
    flags.stop         = (rdata.mark == MARK_EMPTY) || (rd_full && (home_r > home_c));
    flags.step_to_head = (s_nxt == head);
    flags.rd_empty     = (rdata.mark == MARK_EMPTY);
    flags.rd_full      = rd_full;
    flags.scan_more    = rd_full && (n_sh < CNT_W'(SLOTS));
    flags.copy_done    = (p[IDX_W-1:0] == s);
    flags.rb1_done     = (p >= {1'b0, head});
    flags.p_end        = (p >= CNT_W'(SLOTS));
    flags.q_end        = (q >= CNT_W'(SLOTS));
    flags.move_same    = (pn == q);
    flags.ovf_done     = (ovf_i >= ovf_n);
    flags.clr_done     = (p == CNT_W'(SLOTS - 1));
  end

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = s;
    wr_en     = 1'b0;
    wr_addr   = s;
    wr_data   = rdata;
    ovf_wr_en = 1'b0;
    ovf_rd_en = 1'b0;
    unique case (op)
      OP_CLR: begin
        wr_en   = 1'b1;
        wr_addr = p[IDX_W-1:0];
        wr_data = '{mark: MARK_EMPTY, key: '0, value: '0};
      end
      OP_RD_S: begin
        rd_en = 1'b1;
      end
      OP_TOMB: begin
        wr_en        = 1'b1;
        wr_data.mark = MARK_TOMB;
      end
      OP_SCAN_RD: begin
        rd_en   = 1'b1;
        rd_addr = e_nxt;
      end
      OP_COPY_RD: begin
        rd_en   = 1'b1;
        rd_addr = p_prv;
      end
      OP_COPY_WR: begin
        wr_en   = 1'b1;
        wr_addr = p[IDX_W-1:0];
      end
      OP_PLACE, OP_PLACE_RB: begin
        wr_en   = 1'b1;
        wr_data = '{mark: MARK_FULL, key: ckey, value: cval};
      end
      OP_RB1_RD, OP_RB2_PRD, OP_RB4_RD: begin
        rd_en   = 1'b1;
        rd_addr = p[IDX_W-1:0];
      end
      OP_RB1_EX: begin
        wr_en        = 1'b1;
        wr_addr      = p[IDX_W-1:0];
        wr_data.mark = MARK_EMPTY;
        ovf_wr_en    = rd_full;
      end
      OP_RB2_QRD: begin
        rd_en   = 1'b1;
        rd_addr = q[IDX_W-1:0];
      end
      OP_RB2_QCLR, OP_RB2_CLR: begin
        wr_en        = 1'b1;
        wr_addr      = q[IDX_W-1:0];
        wr_data.mark = MARK_EMPTY;
      end
      OP_RB2_MOVE: begin
        wr_en   = (pn != q);
        wr_addr = pn[IDX_W-1:0];
      end
      OP_RB3_RD: begin
        ovf_rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= tbl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ovf_wr_en) begin
      ovf_mem[ovf_n[IDX_W-1:0]] <= '{key: rdata.key, value: rdata.value};
    end
    if (ovf_rd_en) begin
      ovf_rdata <= ovf_mem[ovf_i[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      rec  <= '0;
      tomb <= '0;
      cd   <= CNT_W'(SLOTS / 2);
      p    <= '0;
    end else begin
      unique case (op)
        OP_CLR: begin
          p <= p + 1'b1;
        end
        OP_LOAD: begin
          ckey  <= key;
          cval  <= value_in;
          p     <= '0;
          ovf_n <= '0;
        end
        OP_RES_FULL: begin
          res_status <= ST_FULL;
          res_value  <= '0;
          res_miss   <= '0;
        end
        OP_PINIT: begin
          s       <= (home_c > head) ? home_c : head;
          m       <= '0;
          wrapped <= 1'b0;
        end
        OP_PSTEP: begin
          s <= s_nxt;
          m <= m + 1'b1;
          if (s_nxt == '0) begin
            wrapped <= 1'b1;
          end
        end
        OP_RES_DUP: begin
          res_status <= ST_DUPLICATE;
          res_value  <= '0;
          res_miss   <= m;
        end
        OP_RES_NF: begin
          res_status <= ST_NOT_FOUND;
          res_value  <= '0;
          res_miss   <= m;
        end
        OP_RES_QHIT: begin
          res_status <= ST_OK;
          res_value  <= rdata.value;
          res_miss   <= m;
        end
        OP_TOMB: begin
          tomb       <= tomb + 1'b1;
          rec        <= rec_dec;
          res_status <= ST_OK;
          res_value  <= '0;
          res_miss   <= m;
        end
        OP_EMPTY_HEAD: begin
          if (wrapped && (s == head)) begin
            head <= nxt_slot(head);
          end
        end
        OP_SCAN_INIT: begin
          e    <= s;
          n_sh <= '0;
        end
        OP_SCAN_RD: begin
          e    <= e_nxt;
          n_sh <= n_sh + 1'b1;
        end
        OP_SCAN_END: begin
          if ((rdata.mark == MARK_TOMB) && (tomb != '0)) begin
            tomb <= tomb - 1'b1;
          end
          p <= {1'b0, e};
          // The shift pushed a record across the wrap into the head region.
          if (((e < s) || wrapped) && (e >= head)) begin
            head <= nxt_slot(head);
          end
        end
        OP_COPY_WR: begin
          p <= {1'b0, p_prv};
        end
        OP_PLACE: begin
          rec        <= rec + 1'b1;
          cd         <= cd_dec;
          res_status <= (cd_dec == '0) ? ST_DUE : ST_OK;
          res_value  <= '0;
          res_miss   <= m;
        end
        OP_PLACE_RB: begin
          rec <= rec + 1'b1;
        end
        OP_RB1_EX: begin
          if (rd_full) begin
            ovf_n <= ovf_n + 1'b1;
            rec   <= rec_dec;
          end
          p <= p + 1'b1;
        end
        OP_RB1_END: begin
          head <= '0;
          p    <= '0;
          q    <= '0;
        end
        OP_RB2_PSKIP, OP_RB2_CLR: begin
          p <= p + 1'b1;
          q <= q + 1'b1;
        end
        OP_RB2_QCLR: begin
          q <= q + 1'b1;
        end
        OP_RB2_MOVE: begin
          if (pn == q) begin
            p <= pn + 1'b1;
            q <= q + 1'b1;
          end else begin
            p <= pn;
          end
        end
        OP_RB3_INIT: begin
          ovf_i <= '0;
        end
        OP_RB3_LD: begin
          ckey  <= ovf_rdata.key;
          cval  <= ovf_rdata.value;
          ovf_i <= ovf_i + 1'b1;
        end
        OP_RB4_INIT: begin
          p    <= '0;
          tomb <= '0;
        end
        OP_RB4_EX: begin
          if (rdata.mark == MARK_TOMB) begin
            tomb <= tomb + 1'b1;
          end
          p <= p + 1'b1;
        end
        OP_RB5: begin
          cd         <= cd_reload;
          res_status <= ST_OK;
          res_value  <= '0;
          res_miss   <= '0;
        end
        OP_OUT: begin
          status       <= res_status;
          value_out    <= res_value;
          probe_misses <= res_miss;
        end
        default: begin
        end
      endcase
    end
  end

  a_rec_bound: assert property (@(posedge clk) disable iff (rst) rec <= CNT_W'(SLOTS))
    else $error("record count beyond table size");
  a_cd_bound: assert property (@(posedge clk) disable iff (rst) cd <= CNT_W'(SLOTS / 2))
    else $error("rebuild countdown beyond its reload value");
  a_head_lookup: assert property (@(posedge clk) disable iff (rst)
      (op == OP_RES_NF || op == OP_TOMB || op == OP_RES_QHIT) |=> $stable(head))
    else $error("head moved on a lookup request");

endmodule

// ===== rtl/olpt_ctrl.sv =====
module olpt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          func,
  output logic                out_valid,
  input  logic                out_stall,
  output olpt_pkg::dp_op_t    op,
  input  olpt_pkg::dp_flags_t flags
);
  import olpt_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_INS_CHK, S_P_INIT, S_P_RD, S_P_EX, S_P_END, S_I_RD, S_I_EX,
    S_SC_RD, S_SC_EX, S_CP_RD, S_CP_EX, S_PLACE, S_RB1_CHK, S_RB1_EX, S_RB2_P,
    S_RB2_PEX, S_RB2_Q, S_RB2_QEX, S_RB2_CLR, S_RB3_CHK, S_RB3_LD, S_RB4_RD,
    S_RB4_EX, S_RB5, S_FIN
  } state_t;

  state_t     state, state_next;
  logic [1:0] func_r, func_r_next;
  logic       rb, rb_next;
  state_t     ins_done;

  assign in_stall = (state != S_IDLE);
  // Reinserts during a rebuild return to the overflow loop instead of answering.
  assign ins_done = rb ? S_RB3_CHK : S_FIN;

  always_comb begin
    state_next  = state;
    func_r_next = func_r;
    rb_next     = rb;
    op          = OP_NONE;
    unique case (state)
      S_CLR: begin
        op = OP_CLR;
        if (flags.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op          = OP_LOAD;
          func_r_next = func;
          rb_next     = 1'b0;
          unique case (func)
            FN_INSERT:  state_next = S_INS_CHK;
            FN_REBUILD: state_next = S_RB1_CHK;
            default:    state_next = S_P_INIT;
          endcase
        end
      end
      S_INS_CHK: begin
        if (flags.tbl_full) begin
          op         = OP_RES_FULL;
          state_next = ins_done;
        end else begin
          op         = OP_PINIT;
          state_next = S_P_RD;
        end
      end
      S_P_INIT: begin
        op         = OP_PINIT;
        state_next = S_P_RD;
      end
      S_P_RD: begin
        op         = OP_RD_S;
        state_next = S_P_EX;
      end
      S_P_EX: begin
        if (flags.hit) begin
          unique case (func_r)
            FN_INSERT: begin
              op         = OP_RES_DUP;
              state_next = ins_done;
            end
            FN_QUERY: begin
              op         = OP_RES_QHIT;
              state_next = S_FIN;
            end
            default: begin
              op         = OP_TOMB;
              state_next = S_FIN;
            end
          endcase
        end else if (flags.stop) begin
          if (func_r == FN_INSERT) begin
            state_next = S_I_EX;
          end else begin
            op         = OP_RES_NF;
            state_next = S_FIN;
          end
        end else begin
          op         = OP_PSTEP;
          state_next = flags.step_to_head ? S_P_END : S_P_RD;
        end
      end
      S_P_END: begin
        if (func_r == FN_INSERT) begin
          state_next = S_I_RD;
        end else begin
          op         = OP_RES_NF;
          state_next = S_FIN;
        end
      end
      S_I_RD: begin
        op         = OP_RD_S;
        state_next = S_I_EX;
      end
      S_I_EX: begin
        if (flags.rd_empty) begin
          op         = OP_EMPTY_HEAD;
          state_next = S_PLACE;
        end else begin
          op         = OP_SCAN_INIT;
          state_next = S_SC_RD;
        end
      end
      S_SC_RD: begin
        op         = OP_SCAN_RD;
        state_next = S_SC_EX;
      end
      S_SC_EX: begin
        if (flags.scan_more) begin
          state_next = S_SC_RD;
        end else begin
          op         = OP_SCAN_END;
          state_next = S_CP_RD;
        end
      end
      S_CP_RD: begin
        if (flags.copy_done) begin
          state_next = S_PLACE;
        end else begin
          op         = OP_COPY_RD;
          state_next = S_CP_EX;
        end
      end
      S_CP_EX: begin
        op         = OP_COPY_WR;
        state_next = S_CP_RD;
      end
      S_PLACE: begin
        op         = rb ? OP_PLACE_RB : OP_PLACE;
        state_next = ins_done;
      end
      S_RB1_CHK: begin
        if (flags.rb1_done) begin
          op         = OP_RB1_END;
          state_next = S_RB2_P;
        end else begin
          op         = OP_RB1_RD;
          state_next = S_RB1_EX;
        end
      end
      S_RB1_EX: begin
        op         = OP_RB1_EX;
        state_next = S_RB1_CHK;
      end
      S_RB2_P: begin
        if (flags.p_end) begin
          op         = OP_RB3_INIT;
          rb_next    = 1'b1;
          state_next = S_RB3_CHK;
        end else begin
          op         = OP_RB2_PRD;
          state_next = S_RB2_PEX;
        end
      end
      S_RB2_PEX: begin
        if (flags.rd_full) begin
          op         = OP_RB2_PSKIP;
          state_next = S_RB2_P;
        end else begin
          state_next = S_RB2_Q;
        end
      end
      S_RB2_Q: begin
        if (flags.q_end) begin
          op         = OP_RB3_INIT;
          rb_next    = 1'b1;
          state_next = S_RB3_CHK;
        end else begin
          op         = OP_RB2_QRD;
          state_next = S_RB2_QEX;
        end
      end
      S_RB2_QEX: begin
        if (!flags.rd_full) begin
          op         = OP_RB2_QCLR;
          state_next = S_RB2_Q;
        end else begin
          op         = OP_RB2_MOVE;
          state_next = flags.move_same ? S_RB2_P : S_RB2_CLR;
        end
      end
      S_RB2_CLR: begin
        op         = OP_RB2_CLR;
        state_next = S_RB2_P;
      end
      S_RB3_CHK: begin
        if (flags.ovf_done) begin
          op         = OP_RB4_INIT;
          state_next = S_RB4_RD;
        end else begin
          op         = OP_RB3_RD;
          state_next = S_RB3_LD;
        end
      end
      S_RB3_LD: begin
        op          = OP_RB3_LD;
        func_r_next = FN_INSERT;
        state_next  = S_INS_CHK;
      end
      S_RB4_RD: begin
        if (flags.p_end) begin
          state_next = S_RB5;
        end else begin
          op         = OP_RB4_RD;
          state_next = S_RB4_EX;
        end
      end
      S_RB4_EX: begin
        op         = OP_RB4_EX;
        state_next = S_RB4_RD;
      end
      S_RB5: begin
        op         = OP_RB5;
        rb_next    = 1'b0;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          op         = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      func_r    <= FN_INSERT;
      rb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      func_r <= func_r_next;
      rb     <= rb_next;
      if (op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
      (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one still in work");
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
      (state != S_CLR) |=> (state != S_CLR))
    else $error("clearing pass re-entered after reset");
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
      (op == OP_OUT) |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting result");

endmodule

// ===== rtl/ordered_linear_probe_table_top.sv =====
// Ordered linear-probe key/value table, 1024 slots, 32-bit keys and values.
// Request channel: in_valid/in_stall with func, key and value_in; a request is
// taken when in_valid is high and in_stall low. Result channel: out_valid/
// out_stall with status, value_out and probe_misses, one result per request.
// After reset the block runs a clearing pass over every slot of the memory,
// with in_stall held high; the counters and head are cleared and
// the rebuild countdown is set to 512.
// One request is in work at a time. Each slot visited by a probe is read from
// the table memory in S_P_RD and its registered data is examined in S_P_EX.
// An insert also scans the cluster it shifts and copies each of its slots one
// place on. A rebuild sweeps the memory several times.
// A finished result sits in the output register; the next request is taken
// while it waits, and its own result is held back until the receiver lifts
// out_stall.
module ordered_linear_probe_table_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    func,
  input  logic [olpt_pkg::KEY_W-1:0]    key,
  input  logic [olpt_pkg::VAL_W-1:0]    value_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [olpt_pkg::STAT_W-1:0]   status,
  output logic [olpt_pkg::VAL_W-1:0]    value_out,
  output logic [olpt_pkg::CNT_W-1:0]    probe_misses
);
  import olpt_pkg::*;

  dp_op_t    op;
  dp_flags_t flags;

  olpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .op        (op),
    .flags     (flags)
  );

  olpt_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .key          (key),
    .value_in     (value_in),
    .flags        (flags),
    .status       (status),
    .value_out    (value_out),
    .probe_misses (probe_misses)
  );

endmodule
